FILE: rtl/core/bat_pkg.sv
`default_nettype none

package bat_pkg;

  localparam int DEF_MAX_ENTRIES = 64;
  localparam int DEF_DATA_WIDTH  = 32;

  localparam int CMD_W   = 3;
  localparam int INDEX_W = 6;
  localparam int VALUE_W = 32;
  localparam int RD_W    = 32;
  localparam int ST_W    = 2;
  localparam int COUNT_W = 7;
  localparam int CAP_W   = 7;

  localparam logic [CAP_W-1:0] CAP_RESET = 7'd50;

  localparam logic [CMD_W-1:0] CMD_APPEND = 3'd0;
  localparam logic [CMD_W-1:0] CMD_READ   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_WRITE  = 3'd2;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

  localparam logic [ST_W-1:0] ST_OK        = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
  localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [ST_W-1:0] ST_RANGE     = 2'd3;

  typedef struct packed {
    logic lt;
    logic eq;
  } cmp_res_t;

endpackage

`default_nettype wire

FILE: rtl/core/bounded_array_table_top.sv
// Append, write, clear, unused codes and rejected reads go from dispatch straight to the
// finishing state; a read first waits for the registered entry memory read; a delete, found
// or not, walks the entries held through the registered read and the one shared compare unit.
// Only one request is in flight at a time; the next is accepted after its result is staged,
// and staging waits while an earlier result is stalled.
// Reset (rst, synchronous, active high) empties the table and sets the capacity to 50.
`default_nettype none

module bounded_array_table_top #(
  parameter int MAX_ENTRIES = bat_pkg::DEF_MAX_ENTRIES,
  parameter int DATA_WIDTH  = bat_pkg::DEF_DATA_WIDTH
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic [6:0]  cfg_data,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // tdata: command [2:0], index [8:3], value [40:9], zero [47:41]
  input  wire logic [47:0] s_tdata,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // tdata: read_value [31:0], status [33:32], count [40:34], is_empty [41],
  // is_full [42], zero [47:43]
  output logic      [47:0] m_tdata
);

  // Entry contents are not cleared and no clearing pass is needed.

  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > bat_pkg::COUNT_W) ? CNT_W : bat_pkg::COUNT_W;
  localparam logic [CMP_W-1:0] MAX_C = CMP_W'(MAX_ENTRIES);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DISP = 3'd1;
  localparam logic [2:0] S_RDW  = 3'd2;
  localparam logic [2:0] S_SRD  = 3'd3;
  localparam logic [2:0] S_SCMP = 3'd4;
  localparam logic [2:0] S_SHRD = 3'd5;
  localparam logic [2:0] S_SHWR = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]                      state;
  logic [bat_pkg::CAP_W-1:0]       cap_reg;
  logic [CNT_W-1:0]                fill_count;
  logic [CNT_W-1:0]                ptr;
  logic [bat_pkg::CMD_W-1:0]       cmd;
  logic [bat_pkg::INDEX_W-1:0]     idx;
  logic [DATA_WIDTH-1:0]           key;
  logic [DATA_WIDTH-1:0]           rd_st;
  logic [bat_pkg::ST_W-1:0]        st_st;
  logic                            out_valid;
  logic [bat_pkg::RD_W-1:0]        out_rd;
  logic [bat_pkg::ST_W-1:0]        out_st;
  logic [bat_pkg::COUNT_W-1:0]     out_cnt;
  logic                            out_empty;
  logic                            out_full;

  logic [CMP_W-1:0]      cap_ext;
  logic [CMP_W-1:0]      cap_eff;
  logic [CMP_W-1:0]      cnt_ext;
  logic [CMP_W-1:0]      idx_ext;
  logic [CMP_W-1:0]      ptr_ext;
  logic [CMP_W-1:0]      u_lhs;
  logic [CMP_W-1:0]      u_rhs;
  logic                  u_inc;
  logic [CMP_W-1:0]      u_sum;
  bat_pkg::cmp_res_t     u_res;

  logic                  mem_we;
  logic [AW-1:0]         mem_waddr;
  logic [DATA_WIDTH-1:0] mem_wdata;
  logic                  mem_re;
  logic [AW-1:0]         mem_raddr;
  logic [DATA_WIDTH-1:0] mem_rdata;

  assign cap_ext = CMP_W'(cap_reg);
  assign cap_eff = (cap_ext > MAX_C) ? MAX_C : cap_ext;
  assign cnt_ext = CMP_W'(fill_count);
  assign idx_ext = CMP_W'(idx);
  assign ptr_ext = CMP_W'(ptr);

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign m_tdata  = {5'd0, out_full, out_empty, out_cnt, out_st, out_rd};

  always_comb begin
    u_lhs = ptr_ext;
    u_rhs = cnt_ext;
    u_inc = 1'b0;
    case (state)
      S_DISP: begin
        if (cmd == bat_pkg::CMD_APPEND) begin
          u_lhs = cnt_ext;
          u_rhs = cap_eff;
        end else begin
          u_lhs = idx_ext;
        end
      end
      S_SHRD: begin
        u_inc = 1'b1;
      end
      S_DONE: begin
        u_lhs = cnt_ext;
        u_rhs = cap_eff;
      end
      default: begin
      end
    endcase
  end

  bat_cmp #(
    .W  (CMP_W),
    .DW (DATA_WIDTH)
  ) u_cmp (
    .lhs     (u_lhs),
    .rhs     (u_rhs),
    .inc_lhs (u_inc),
    .da      (mem_rdata),
    .db      (key),
    .sum     (u_sum),
    .res     (u_res)
  );

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_ext[AW-1:0];
    mem_wdata = key;
    mem_re    = 1'b0;
    mem_raddr = ptr_ext[AW-1:0];
    case (state)
      S_DISP: begin
        if (cmd == bat_pkg::CMD_APPEND) begin
          mem_we    = u_res.lt;
          mem_waddr = cnt_ext[AW-1:0];
        end else if (cmd == bat_pkg::CMD_WRITE) begin
          mem_we    = u_res.lt;
          mem_waddr = idx_ext[AW-1:0];
        end else if (cmd == bat_pkg::CMD_READ) begin
          mem_re    = u_res.lt;
          mem_raddr = idx_ext[AW-1:0];
        end
      end
      S_SRD: begin
        mem_re = u_res.lt;
      end
      S_SHRD: begin
        mem_re    = u_res.lt;
        mem_raddr = u_sum[AW-1:0];
      end
      S_SHWR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata;
      end
      default: begin
      end
    endcase
  end

  bat_mem #(
    .DW    (DATA_WIDTH),
    .DEPTH (MAX_ENTRIES),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cap_reg <= bat_pkg::CAP_RESET;
    end else if (cfg_we) begin
      cap_reg <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      fill_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      // In the finishing state the staging below decides the valid flag.
      if (out_valid && m_tready && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            cmd   <= s_tdata[2:0];
            idx   <= s_tdata[8:3];
            key   <= DATA_WIDTH'(s_tdata[40:9]);
            rd_st <= '0;
            st_st <= bat_pkg::ST_OK;
            ptr   <= '0;
            state <= S_DISP;
          end
        end
        S_DISP: begin
          case (cmd)
            bat_pkg::CMD_APPEND: begin
              if (u_res.lt) begin
                fill_count <= fill_count + CNT_W'(1);
              end else begin
                st_st <= bat_pkg::ST_FULL;
              end
              state <= S_DONE;
            end
            bat_pkg::CMD_READ: begin
              if (u_res.lt) begin
                state <= S_RDW;
              end else begin
                st_st <= bat_pkg::ST_RANGE;
                state <= S_DONE;
              end
            end
            bat_pkg::CMD_WRITE: begin
              if (!u_res.lt) begin
                st_st <= bat_pkg::ST_RANGE;
              end
              state <= S_DONE;
            end
            bat_pkg::CMD_DELETE: begin
              state <= S_SRD;
            end
            bat_pkg::CMD_CLEAR: begin
              fill_count <= '0;
              state      <= S_DONE;
            end
            default: begin
              state <= S_DONE;
            end
          endcase
        end
        S_RDW: begin
          rd_st <= mem_rdata;
          state <= S_DONE;
        end
        S_SRD: begin
          if (u_res.lt) begin
            state <= S_SCMP;
          end else begin
            st_st <= bat_pkg::ST_NOT_FOUND;
            state <= S_DONE;
          end
        end
        S_SCMP: begin
          if (u_res.eq) begin
            state <= S_SHRD;
          end else begin
            ptr   <= u_sum[CNT_W-1:0];
            state <= S_SRD;
          end
        end
        S_SHRD: begin
          if (u_res.lt) begin
            state <= S_SHWR;
          end else begin
            fill_count <= fill_count - CNT_W'(1);
            state      <= S_DONE;
          end
        end
        S_SHWR: begin
          ptr   <= u_sum[CNT_W-1:0];
          state <= S_SHRD;
        end
        S_DONE: begin
          if (!out_valid || m_tready) begin
            out_valid <= 1'b1;
            out_rd    <= bat_pkg::RD_W'(rd_st);
            out_st    <= st_st;
            out_cnt   <= cnt_ext[bat_pkg::COUNT_W-1:0];
            out_empty <= (fill_count == '0);
            out_full  <= !u_res.lt;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bat_mem.sv
`default_nettype none

module bat_mem #(
  parameter int DW    = bat_pkg::DEF_DATA_WIDTH,
  parameter int DEPTH = bat_pkg::DEF_MAX_ENTRIES,
  parameter int AW    = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/bat_cmp.sv
`default_nettype none

module bat_cmp #(
  parameter int W  = 7,
  parameter int DW = bat_pkg::DEF_DATA_WIDTH
) (
  input  wire logic [W-1:0]  lhs,
  input  wire logic [W-1:0]  rhs,
  input  wire logic          inc_lhs,
  input  wire logic [DW-1:0] da,
  input  wire logic [DW-1:0] db,
  output logic      [W-1:0]  sum,
  output bat_pkg::cmp_res_t  res
);

  logic [W-1:0] cmp_l;

  // The incremented operand feeds the less-than compare when asked, so
  // that "next position still inside the table" is one step.
  assign sum    = lhs + W'(1);
  assign cmp_l  = inc_lhs ? sum : lhs;
  assign res.lt = cmp_l < rhs;
  assign res.eq = da == db;

endmodule

`default_nettype wire

FILE: rtl/core/bat_checker.sv
`default_nettype none

module bat_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [47:0] m_tdata
);

  // A stalled result must hold its contents.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // Only one request is in flight at a time.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("request accepted while busy");

  // A rejected append always reports a full table.
  a_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:32] == 2'd1) |-> m_tdata[42])
    else $error("full status without full flag");

  // Any failing request returns a zero read value.
  a_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[33:32] != 2'd0) |-> (m_tdata[31:0] == 32'd0))
    else $error("non-zero read value on failed request");

  // Reset drops any pending result.
  a_rst: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid after reset");

endmodule

bind bounded_array_table_top bat_checker u_bat_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
